/* sv/fsls_pkg.sv */
// Shared types and constants for the frame slot lock selector.
package fsls_pkg;

  localparam int SLOT_CAP      = 8;
  localparam int SLOT_W        = 3;
  localparam int SEQ_W         = 64;
  localparam int ATTEMPTS_W    = 8;
  localparam int NUM_SLOTS_DEF = 4;

  typedef enum logic [1:0] {
    MODE_LATEST = 2'd0,
    MODE_OLDEST = 2'd1,
    MODE_SET    = 2'd2,
    MODE_UNLOCK = 2'd3
  } mode_t;

  // scan token walking the cell row
  typedef struct packed {
    logic              valid;
    mode_t             mode;
    logic              fail;
    logic              found;
    logic [SLOT_W-1:0] sel;
    logic [SLOT_W-1:0] pick;
    logic [SEQ_W-1:0]  seq;
  } token_t;

  // state update broadcast to all cells at the end of a scan
  typedef struct packed {
    logic              en;
    mode_t             mode;
    logic [SLOT_W-1:0] slot;
    logic [SEQ_W-1:0]  seq;
  } commit_t;

endpackage

/* sv/fsls_cell.sv */
// One slot cell: lock bit, sequence, and one stage of the scan token.
module fsls_cell #(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             hold,
  input  fsls_pkg::token_t  tok_in,
  input  fsls_pkg::commit_t commit,
  output fsls_pkg::token_t  tok_out
);

  localparam logic [fsls_pkg::SLOT_W-1:0] MY_SLOT = fsls_pkg::SLOT_W'(IDX);

  logic                        lock;
  logic [fsls_pkg::SEQ_W-1:0]  seq;
  fsls_pkg::token_t            tok;
  fsls_pkg::token_t            tok_next;

  always_comb begin
    tok_next = tok_in;
    if (tok_in.valid && !tok_in.fail) begin
      case (tok_in.mode)
        fsls_pkg::MODE_LATEST: begin
          if (!lock && (seq != '0) && (!tok_in.found || (seq > tok_in.seq))) begin
            tok_next.found = 1'b1;
            tok_next.pick  = MY_SLOT;
            tok_next.seq   = seq;
          end
        end
        fsls_pkg::MODE_OLDEST: begin
          if (!lock && (!tok_in.found || (seq < tok_in.seq))) begin
            tok_next.found = 1'b1;
            tok_next.pick  = MY_SLOT;
            tok_next.seq   = seq;
          end
        end
        fsls_pkg::MODE_SET: begin
          if (tok_in.sel == MY_SLOT) begin
            tok_next.found = 1'b1;
            tok_next.pick  = MY_SLOT;
          end
        end
        fsls_pkg::MODE_UNLOCK: begin
          if (tok_in.sel == MY_SLOT) begin
            tok_next.found = 1'b1;
            tok_next.pick  = MY_SLOT;
            tok_next.seq   = seq;
          end
        end
        default: begin
          tok_next = tok_in;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok.valid <= 1'b0;
    end else if (!hold) begin
      tok <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lock <= 1'b0;
      seq  <= '0;
    end else if (commit.en && (commit.slot == MY_SLOT)) begin
      case (commit.mode) inside
        fsls_pkg::MODE_LATEST, fsls_pkg::MODE_OLDEST: begin
          lock <= 1'b1;
        end
        fsls_pkg::MODE_SET: begin
          seq <= commit.seq;
        end
        default: begin
          lock <= 1'b0;
        end
      endcase
    end
  end

  assign tok_out = tok;

endmodule

/* sv/frame_slot_lock_selector.sv */
// Frame slot lock selector: a row of slot cells scanned by a walking token.
// Each request enters the cell row as a token that moves one cell per clock unless the
// last cell holds a result that the stalled output cannot take; a new beat is taken
// only after the previous token has left the row. The chosen slot is locked, written
// or unlocked in the cycle the result is loaded into the output register, and the
// next beat may enter while that result waits.
// Failures return ok=0 with slot_out and sequence_out zero.
module frame_slot_lock_selector #(
  parameter int NUM_SLOTS = fsls_pkg::NUM_SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       mode,
  input  logic [fsls_pkg::SLOT_W-1:0]      slot_sel,
  input  logic [fsls_pkg::SEQ_W-1:0]       new_sequence,
  input  logic [fsls_pkg::ATTEMPTS_W-1:0]  attempts,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             ok,
  output logic [fsls_pkg::SLOT_W-1:0]      slot_out,
  output logic [fsls_pkg::SEQ_W-1:0]       sequence_out
);

  localparam int N = (NUM_SLOTS > fsls_pkg::SLOT_CAP) ? fsls_pkg::SLOT_CAP : NUM_SLOTS;

  fsls_pkg::token_t  toks [N+1];
  fsls_pkg::token_t  last;
  fsls_pkg::commit_t commit;
  fsls_pkg::mode_t   in_mode;
  logic              busy;
  logic              in_acc;
  logic              fire;
  logic              hold;
  logic              res_ok;

  assign in_mode  = fsls_pkg::mode_t'(mode);
  assign in_stall = busy;
  assign in_acc   = in_valid && !busy;

  always_comb begin
    toks[0].valid = in_acc;
    toks[0].mode  = in_mode;
    toks[0].fail  = ((in_mode == fsls_pkg::MODE_LATEST) || (in_mode == fsls_pkg::MODE_OLDEST))
                    && (attempts == '0);
    toks[0].found = 1'b0;
    toks[0].sel   = slot_sel;
    toks[0].pick  = '0;
    toks[0].seq   = (in_mode == fsls_pkg::MODE_SET) ? new_sequence : '0;
  end

  assign last   = toks[N];
  assign fire   = last.valid && (!out_valid || !out_stall);
  assign hold   = last.valid && !fire;
  assign res_ok = last.found && !last.fail;

  always_comb begin
    commit.en   = fire && res_ok;
    commit.mode = last.mode;
    commit.slot = last.pick;
    commit.seq  = last.seq;
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    fsls_cell #(
      .IDX(g)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .hold   (hold),
      .tok_in (toks[g]),
      .commit (commit),
      .tok_out(toks[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (in_acc) begin
      busy <= 1'b1;
    end else if (fire) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      ok           <= res_ok;
      slot_out     <= res_ok ? last.pick : '0;
      sequence_out <= res_ok ? last.seq : '0;
    end
  end

endmodule

/* sv/fsls_checker.sv */
// Port-level checks for the frame slot lock selector, bound to the top level.
module fsls_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic                             ok,
  input logic [fsls_pkg::SLOT_W-1:0]      slot_out,
  input logic [fsls_pkg::SEQ_W-1:0]       sequence_out
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !ok) |-> ((slot_out == '0) && (sequence_out == '0)))
    else $error("failed beat carries nonzero slot or sequence");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again while a beat is in the cell row");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(ok) && $stable(slot_out)
                                  && $stable(sequence_out)))
    else $error("stalled result beat changed");

endmodule

bind frame_slot_lock_selector fsls_checker u_fsls_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .ok          (ok),
  .slot_out    (slot_out),
  .sequence_out(sequence_out)
);

/* dv/frame_slot_lock_selector_tb.sv */
// Self-checking testbench for frame_slot_lock_selector: directed and random requests
`timescale 1ns / 100ps

module frame_slot_lock_selector_tb;

  localparam int N_SLOTS     = fsls_pkg::NUM_SLOTS_DEF;
  localparam int ITEMS       = 1850;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 4 * (N_SLOTS + 1) + 10;

  typedef struct packed {
    logic                        ok;
    logic [fsls_pkg::SLOT_W-1:0] slot;
    logic [fsls_pkg::SEQ_W-1:0]  seq;
  } slot_result_t;

  // mirror of the slot pool; predicts one result per request beat
  class slot_pool_sb;
    bit                         locked [fsls_pkg::SLOT_CAP];
    logic [fsls_pkg::SEQ_W-1:0] seqs [fsls_pkg::SLOT_CAP];
    int                         n_slots;
    slot_result_t               want_q [$];
    int                         errors, checked;
    int                         grants, refusals, writes, unlocks, out_of_range;

    function new(int n);
      n_slots = (n > fsls_pkg::SLOT_CAP) ? fsls_pkg::SLOT_CAP : n;
      for (int i = 0; i < fsls_pkg::SLOT_CAP; i++) begin
        locked[i] = 1'b0;
        seqs[i]   = '0;
      end
      errors = 0;
      checked = 0;
      grants = 0;
      refusals = 0;
      writes = 0;
      unlocks = 0;
      out_of_range = 0;
    endfunction

    function void note_request(logic [1:0] md, logic [fsls_pkg::SLOT_W-1:0] sel,
                               logic [fsls_pkg::SEQ_W-1:0] nseq,
                               logic [fsls_pkg::ATTEMPTS_W-1:0] att);
      slot_result_t               r;
      fsls_pkg::mode_t            m;
      bit                         found;
      int                         pick;
      logic [fsls_pkg::SEQ_W-1:0] best;
      m = fsls_pkg::mode_t'(md);
      r = '0;
      found = 1'b0;
      pick = 0;
      best = '0;
      if (m == fsls_pkg::MODE_LATEST || m == fsls_pkg::MODE_OLDEST) begin
        if (att != '0) begin
          for (int i = 0; i < n_slots; i++) begin
            if (!locked[i]) begin
              if (m == fsls_pkg::MODE_LATEST) begin
                if (seqs[i] != '0 && (!found || seqs[i] > best)) begin
                  found = 1'b1;
                  pick = i;
                  best = seqs[i];
                end
              end else if (!found || seqs[i] < best) begin
                found = 1'b1;
                pick = i;
                best = seqs[i];
              end
            end
          end
        end
        if (found) begin
          locked[pick] = 1'b1;
          r.ok = 1'b1;
          r.slot = pick[fsls_pkg::SLOT_W-1:0];
          r.seq = best;
          grants++;
        end else begin
          refusals++;
        end
      end else if (int'(sel) >= n_slots) begin
        out_of_range++;
      end else if (m == fsls_pkg::MODE_SET) begin
        seqs[sel] = nseq;
        r.ok = 1'b1;
        r.slot = sel;
        r.seq = nseq;
        writes++;
      end else begin
        locked[sel] = 1'b0;
        r.ok = 1'b1;
        r.slot = sel;
        r.seq = seqs[sel];
        unlocks++;
      end
      want_q.push_back(r);
    endfunction

    function void check_result(logic ok_a, logic [fsls_pkg::SLOT_W-1:0] slot_a,
                               logic [fsls_pkg::SEQ_W-1:0] seq_a);
      slot_result_t w;
      if (want_q.size() == 0) begin
        if (errors < 10)
          $display("[%0t] result beat with no request pending: ok=%0b slot=%0d seq=%h",
                   $time, ok_a, slot_a, seq_a);
        errors++;
      end else begin
        w = want_q.pop_front();
        if (ok_a !== w.ok || slot_a !== w.slot || seq_a !== w.seq) begin
          if (errors < 10)
            $display("[%0t] result %0d mismatch: exp ok=%0b slot=%0d seq=%h, %s%0b %s%0d %s%h",
                     $time, checked, w.ok, w.slot, w.seq,
                     "got ok=", ok_a, "slot=", slot_a, "seq=", seq_a);
          errors++;
        end
        checked++;
      end
    endfunction

    function int pending();
      return want_q.size();
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            in_valid;
  logic                            in_stall;
  logic [1:0]                      mode;
  logic [fsls_pkg::SLOT_W-1:0]     slot_sel;
  logic [fsls_pkg::SEQ_W-1:0]      new_sequence;
  logic [fsls_pkg::ATTEMPTS_W-1:0] attempts;
  logic                            out_valid;
  logic                            out_stall;
  logic                            ok;
  logic [fsls_pkg::SLOT_W-1:0]     slot_out;
  logic [fsls_pkg::SEQ_W-1:0]      sequence_out;

  slot_pool_sb sb;
  int          n_sent;
  int          cycle_cnt;
  bit          steady;

  frame_slot_lock_selector #(
    .NUM_SLOTS(N_SLOTS)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .slot_sel    (slot_sel),
    .new_sequence(new_sequence),
    .attempts    (attempts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .ok          (ok),
    .slot_out    (slot_out),
    .sequence_out(sequence_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, sb.pending());
    $display("Some tests failed");
    $finish;
  end

  // mostly short idle runs, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [fsls_pkg::SEQ_W-1:0] pick_seq();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return fsls_pkg::SEQ_W'($urandom_range(0, 6));
    if (r < 40) return '0;
    if (r < 45) return '1;
    if (r < 50) return {1'b1, {(fsls_pkg::SEQ_W-1){1'b0}}};
    return {$urandom, $urandom};
  endfunction

  function automatic logic [fsls_pkg::ATTEMPTS_W-1:0] pick_attempts();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return fsls_pkg::ATTEMPTS_W'($urandom_range(1, 255));
  endfunction

  // beats checked before requests are noted: a result never shares an edge with its own request
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        sb.check_result(ok, slot_out, sequence_out);
      if (in_valid && !in_stall)
        sb.note_request(mode, slot_sel, new_sequence, attempts);
    end
  end

  initial begin
    int run;
    run = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (run > 0) begin
        run--;
      end else if (steady) begin
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 99) < 40) begin
        out_stall <= 1'b1;
        run = idle_len() - 1;
      end else begin
        out_stall <= 1'b0;
        run = $urandom_range(0, 6);
      end
    end
  end

  task automatic send_request(fsls_pkg::mode_t m, logic [fsls_pkg::SLOT_W-1:0] sel,
                              logic [fsls_pkg::SEQ_W-1:0] sq,
                              logic [fsls_pkg::ATTEMPTS_W-1:0] att);
    int g;
    g = (steady || $urandom_range(0, 99) < 60) ? 0 : idle_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid     <= 1'b1;
    mode         <= m;
    slot_sel     <= sel;
    new_sequence <= sq;
    attempts     <= att;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    logic [fsls_pkg::SEQ_W-1:0]  frame_no;
    int                          next_drain;
    int                          r;
    logic [fsls_pkg::SLOT_W-1:0] s;
    sb = new(N_SLOTS);
    n_sent = 0;
    steady = 1'b0;
    frame_no = 64'd1;
    next_drain = 400;
    rst = 1'b1;
    in_valid = 1'b0;
    mode = fsls_pkg::MODE_LATEST;
    slot_sel = '0;
    new_sequence = '0;
    attempts = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty pool, zero attempts, out of range slots
    send_request(fsls_pkg::MODE_LATEST, 3'd0, {$urandom, $urandom}, 8'd1);
    send_request(fsls_pkg::MODE_LATEST, 3'd0, '0, 8'd0);
    send_request(fsls_pkg::MODE_OLDEST, 3'd0, '1, 8'd0);
    send_request(fsls_pkg::MODE_OLDEST, 3'd5, '1, 8'hFF);
    send_request(fsls_pkg::MODE_SET, 3'd4, '1, 8'd3);
    send_request(fsls_pkg::MODE_UNLOCK, 3'd7, '0, 8'd0);
    // fill, with a tie at the top value
    send_request(fsls_pkg::MODE_SET, 3'd0, '1, 8'd0);
    send_request(fsls_pkg::MODE_SET, 3'd1, 64'd1, 8'hFF);
    send_request(fsls_pkg::MODE_SET, 3'd2, '1, 8'd0);
    send_request(fsls_pkg::MODE_SET, 3'd3, {1'b1, {(fsls_pkg::SEQ_W-1){1'b0}}}, 8'd0);
    // lock until nothing qualifies
    send_request(fsls_pkg::MODE_LATEST, 3'd6, '0, 8'd1);
    send_request(fsls_pkg::MODE_LATEST, 3'd0, '0, 8'h80);
    send_request(fsls_pkg::MODE_LATEST, 3'd0, '0, 8'hFF);
    send_request(fsls_pkg::MODE_LATEST, 3'd0, '0, 8'd1);
    send_request(fsls_pkg::MODE_OLDEST, 3'd0, '0, 8'd7);
    // unlock twice, write into a locked slot
    send_request(fsls_pkg::MODE_UNLOCK, 3'd0, '1, 8'd0);
    send_request(fsls_pkg::MODE_UNLOCK, 3'd0, '0, 8'd0);
    send_request(fsls_pkg::MODE_SET, 3'd1, '0, 8'd0);
    send_request(fsls_pkg::MODE_UNLOCK, 3'd1, '0, 8'd0);
    send_request(fsls_pkg::MODE_UNLOCK, 3'd2, '0, 8'd0);
    send_request(fsls_pkg::MODE_UNLOCK, 3'd3, '0, 8'd0);
    send_request(fsls_pkg::MODE_OLDEST, 3'd0, '0, 8'd2);
    send_request(fsls_pkg::MODE_LATEST, 3'd0, '0, 8'hFF);
    drain_results();

    while (n_sent < ITEMS) begin
      steady = ((n_sent % 250) < 40);
      r = $urandom_range(0, 99);
      s = fsls_pkg::SLOT_W'($urandom_range(0, N_SLOTS - 1));
      if (r < 30) begin
        // producer: claim the oldest buffer, then stamp a frame into and release slot s
        send_request(fsls_pkg::MODE_OLDEST, 3'($urandom), {$urandom, $urandom},
                     fsls_pkg::ATTEMPTS_W'($urandom_range(1, 255)));
        send_request(fsls_pkg::MODE_SET, s, frame_no, pick_attempts());
        send_request(fsls_pkg::MODE_UNLOCK, s, {$urandom, $urandom}, pick_attempts());
        frame_no = frame_no + 64'd1;
      end else if (r < 55) begin
        // consumer: take the newest frame, release some slot
        send_request(fsls_pkg::MODE_LATEST, 3'($urandom), {$urandom, $urandom},
                     fsls_pkg::ATTEMPTS_W'($urandom_range(1, 255)));
        send_request(fsls_pkg::MODE_UNLOCK, s, {$urandom, $urandom}, pick_attempts());
      end else if (r < 62) begin
        send_request(fsls_pkg::MODE_SET, s, frame_no, pick_attempts());
        frame_no = frame_no + 64'd1;
      end else begin
        send_request(fsls_pkg::mode_t'($urandom_range(0, 3)),
                     ($urandom_range(0, 99) < 85) ? s : 3'($urandom_range(N_SLOTS, 7)),
                     pick_seq(), pick_attempts());
      end
      if (n_sent >= next_drain) begin
        drain_results();
        next_drain += 400;
      end
    end

    drain_results();
    repeat (SETTLE) @(posedge clk);

    $display("%0d requests, %0d results checked: %0d locks granted, %0d refused,",
             n_sent, sb.checked, sb.grants, sb.refusals);
    $display("%0d sequence writes, %0d unlocks, %0d out-of-range accesses, %0d errors",
             sb.writes, sb.unlocks, sb.out_of_range, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
